[rtl/ptes_pkg.sv]
// ----------------------------------------------------------------------------
// Portal table escape select package
// Shared command, status and controller-to-datapath types.
// ----------------------------------------------------------------------------
package ptes_pkg;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_ESCAPE = 2'd2;

    localparam logic [2:0] ST_CLEARED = 3'd0;
    localparam logic [2:0] ST_NEW     = 3'd1;
    localparam logic [2:0] ST_UPDATED = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_FOUND   = 3'd4;
    localparam logic [2:0] ST_NONE    = 3'd5;

    localparam int unsigned COUNT_BITS = 7;
    localparam int unsigned INDEX_BITS = 6;

    // Controller commands to the datapath
    typedef struct packed {
        logic load;      // capture input item, reset scan bookkeeping
        logic clear;     // clear the table
        logic rd_en;     // issue read of entry at scan pointer
        logic eval;      // evaluate read data of previous entry
        logic write;     // write insert item at chosen entry
        logic finish;    // form result
    } ptes_cmd_t;

    typedef struct packed {
        logic       last_rd;  // scan pointer at last entry
        logic [1:0] cmd;      // captured command
    } ptes_stat_t;

endpackage

[rtl/ptes_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module ptes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/ptes_ctrl.sv]
// ----------------------------------------------------------------------------
// Portal table controller
// Sequences accept, entry scan, table write and result strobe.
// ----------------------------------------------------------------------------
module ptes_ctrl
    import ptes_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output ptes_cmd_t  ctl,
    input  ptes_stat_t stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.cmd == CMD_INSERT || stat.cmd == CMD_ESCAPE)
                begin
                    ctl.rd_en = 1'b1;
                    if (stat.last_rd)
                    begin
                        state_next = S_LAST;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
                ctl.eval = 1'b0;
            end
            S_LAST:
            begin
                ctl.eval   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                ctl.clear  = (stat.cmd == CMD_CLEAR);
                ctl.write  = (stat.cmd == CMD_INSERT);
                ctl.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Result strobe ends every command, and only while busy
    a_finish_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |-> !start || busy)
        else $error("finish outside busy");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> busy)
        else $error("load did not enter scan");
    a_last_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LAST) |=> (state_reg == S_DONE))
        else $error("last read not followed by result");

endmodule

[rtl/ptes_datapath.sv]
// ----------------------------------------------------------------------------
// Portal table datapath
// Table memory, valid bits, scan pointer, match, distance and direction compare.
// ----------------------------------------------------------------------------
module ptes_datapath
    import ptes_pkg::*;
#(
    parameter int PORTALS    = 64,
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ptes_cmd_t                    ctl,
    output ptes_stat_t                   stat,
    input  logic [1:0]                   cmd,
    input  logic [7:0]                   group_a,
    input  logic [7:0]                   group_b,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic signed [COORD_BITS-1:0] pos_z,
    input  logic signed [COORD_BITS-1:0] from_x,
    input  logic signed [COORD_BITS-1:0] from_y,
    input  logic signed [COORD_BITS-1:0] from_z,
    input  logic [7:0]                   start_group,
    input  logic [7:0]                   avoid_group,
    output logic                         done,
    output logic [2:0]                   status,
    output logic [INDEX_BITS-1:0]        portal_index,
    output logic [COUNT_BITS-1:0]        portal_count,
    output logic                         is_ahead,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic signed [COORD_BITS-1:0] out_z
);

    localparam int AW    = $clog2(PORTALS);
    localparam int DW    = COORD_BITS + 1;
    localparam int PW    = 2 * DW;
    localparam int SW    = PW + 2;
    localparam int EW    = 3 * COORD_BITS + 16;
    localparam logic [AW-1:0] LAST = AW'(PORTALS - 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    // Captured item
    logic [1:0]                   cmd_reg;
    logic [7:0]                   lo_reg, hi_reg, sg_reg, ag_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg, pz_reg;
    logic signed [DW-1:0]         ex_reg, ey_reg, ez_reg;

    // Scan bookkeeping
    logic [AW-1:0]                rp_reg, ep_reg;
    logic                         ev_reg;
    logic [PORTALS-1:0]           vld_reg;
    logic [COUNT_BITS-1:0]        cnt_reg;
    logic                         hit_reg, free_reg;
    logic [AW-1:0]                hit_idx_reg, free_idx_reg;
    logic                         bst_v_reg [2];
    logic [AW-1:0]                bst_i_reg [2];
    logic [SW-1:0]                bst_d_reg [2];
    logic signed [COORD_BITS-1:0] bx_reg [2], by_reg [2], bz_reg [2];

    // RAM ports
    logic [EW-1:0] rdata, wdata;
    logic          we;
    logic [AW-1:0] waddr;

    ptes_ram #(.WIDTH(EW), .DEPTH(PORTALS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ctl.rd_en),
        .raddr (rp_reg),
        .rdata (rdata)
    );

    // Entry fields, invalid entries read as zero
    logic [7:0]                   e_lo, e_hi, oth;
    logic signed [COORD_BITS-1:0] e_x, e_y, e_z;
    always_comb
    begin
        {e_lo, e_hi, e_x, e_y, e_z} = vld_reg[ep_reg] ? rdata : '0;
    end

    logic signed [COORD_BITS-1:0] pos_x_cap, pos_y_cap, pos_z_cap;
    assign pos_x_cap = px_reg;
    assign pos_y_cap = py_reg;
    assign pos_z_cap = pz_reg;

    // Distance and direction terms
    logic signed [DW-1:0] dx, dy, dz;
    logic signed [PW-1:0] mxx, myy, mzz, mxe, mye, mze;
    logic signed [SW-1:0] dot;
    logic [SW-1:0]        dsq;
    logic                 cand, side;
    always_comb
    begin
        dx   = DW'(e_x) - DW'(pos_x_cap);
        dy   = DW'(e_y) - DW'(pos_y_cap);
        dz   = DW'(e_z) - DW'(pos_z_cap);
        mxx  = dx * dx;
        myy  = dy * dy;
        mzz  = dz * dz;
        mxe  = dx * ex_reg;
        mye  = dy * ey_reg;
        mze  = dz * ez_reg;
        dot  = SW'(mxe) + SW'(mye) + SW'(mze);
        dsq  = SW'(mxx) + SW'(myy) + SW'(mzz);
        side = dot[SW-1];
        oth  = (e_lo == sg_reg) ? e_hi : e_lo;
        cand = (e_lo != 8'd0) && (e_hi != 8'd0)
            && ((e_lo == sg_reg) || (e_hi == sg_reg)) && (oth != ag_reg);
    end

    logic [AW-1:0] w_idx;
    logic          w_ok;
    assign w_ok  = hit_reg || free_reg;
    assign w_idx = hit_reg ? hit_idx_reg : free_idx_reg;
    assign we    = ctl.write && w_ok;
    assign waddr = w_idx;
    assign wdata = {lo_reg, hi_reg, px_reg, py_reg, pz_reg};

    assign stat.last_rd = (rp_reg == LAST);
    assign stat.cmd     = cmd_reg;

    // Capture, scan and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg      <= CMD_CLEAR;
            rp_reg       <= '0;
            ep_reg       <= '0;
            ev_reg       <= 1'b0;
            vld_reg      <= '0;
            cnt_reg      <= '0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            bst_v_reg[0] <= 1'b0;
            bst_v_reg[1] <= 1'b0;
            done         <= 1'b0;
        end
        else
        begin
            done   <= ctl.finish;
            ev_reg <= ctl.rd_en;
            ep_reg <= rp_reg;
            if (ctl.rd_en)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (ctl.load)
            begin
                cmd_reg      <= cmd;
                rp_reg       <= '0;
                hit_reg      <= 1'b0;
                free_reg     <= 1'b0;
                bst_v_reg[0] <= 1'b0;
                bst_v_reg[1] <= 1'b0;
            end
            // Evaluate the entry read last cycle
            if (ev_reg)
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    if (!hit_reg && e_lo == lo_reg && e_hi == hi_reg)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= ep_reg;
                    end
                    if (!free_reg && (e_lo == 8'd0 || e_hi == 8'd0))
                    begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= ep_reg;
                    end
                end
                else if (cand && (!bst_v_reg[side] || dsq > bst_d_reg[side]))
                begin
                    bst_v_reg[side] <= 1'b1;
                    bst_i_reg[side] <= ep_reg;
                    bst_d_reg[side] <= dsq;
                    bx_reg[side]    <= e_x;
                    by_reg[side]    <= e_y;
                    bz_reg[side]    <= e_z;
                end
            end
            if (ctl.clear)
            begin
                vld_reg <= '0;
                cnt_reg <= '0;
            end
            if (we)
            begin
                vld_reg[w_idx] <= 1'b1;
                if (!hit_reg && cnt_reg != CMAX)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // Captured item fields and result payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            lo_reg <= (group_a < group_b) ? group_a : group_b;
            hi_reg <= (group_a < group_b) ? group_b : group_a;
            sg_reg <= start_group;
            ag_reg <= avoid_group;
            px_reg <= pos_x;
            py_reg <= pos_y;
            pz_reg <= pos_z;
            ex_reg <= DW'(from_x) - DW'(pos_x);
            ey_reg <= DW'(from_y) - DW'(pos_y);
            ez_reg <= DW'(from_z) - DW'(pos_z);
        end
        if (ctl.finish)
        begin
            status       <= ST_NONE;
            portal_index <= '0;
            is_ahead     <= 1'b0;
            out_x        <= '0;
            out_y        <= '0;
            out_z        <= '0;
            case (cmd_reg)
                CMD_CLEAR:
                begin
                    status <= ST_CLEARED;
                end
                CMD_INSERT:
                begin
                    if (w_ok)
                    begin
                        status       <= hit_reg ? ST_UPDATED : ST_NEW;
                        portal_index <= INDEX_BITS'(w_idx);
                        out_x        <= px_reg;
                        out_y        <= py_reg;
                        out_z        <= pz_reg;
                    end
                    else
                    begin
                        status <= ST_FULL;
                    end
                end
                CMD_ESCAPE:
                begin
                    if (bst_v_reg[0])
                    begin
                        status       <= ST_FOUND;
                        is_ahead     <= 1'b1;
                        portal_index <= INDEX_BITS'(bst_i_reg[0]);
                        out_x        <= bx_reg[0];
                        out_y        <= by_reg[0];
                        out_z        <= bz_reg[0];
                    end
                    else if (bst_v_reg[1])
                    begin
                        status       <= ST_FOUND;
                        portal_index <= INDEX_BITS'(bst_i_reg[1]);
                        out_x        <= bx_reg[1];
                        out_y        <= by_reg[1];
                        out_z        <= bz_reg[1];
                    end
                end
                default:
                begin
                    status <= ST_NONE;
                end
            endcase
        end
    end

    assign portal_count = cnt_reg;

    a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> (cnt_reg == '0))
        else $error("count not cleared");
    a_full_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.write && !w_ok) |-> (vld_reg == '1))
        else $error("full reported with free entry");
    a_ev_follows_rd: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rd_en |=> ev_reg)
        else $error("read not evaluated");

endmodule

[rtl/portal_table_escape_select_core.sv]
// ----------------------------------------------------------------------------
// Portal table escape select core
// Portal table with insert, clear and escape-portal search.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy low. Clear raises done
// with the result; insert and escape scan the table through one RAM read
// port, one entry per cycle. The result appears for one cycle with done high
// and must be captured then. portal_count is live and reports the entry count.
module portal_table_escape_select_core
    import ptes_pkg::*;
#(
    parameter int PORTALS    = 64,
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   cmd,
    input  logic [7:0]                   group_a,
    input  logic [7:0]                   group_b,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic signed [COORD_BITS-1:0] pos_z,
    input  logic signed [COORD_BITS-1:0] from_x,
    input  logic signed [COORD_BITS-1:0] from_y,
    input  logic signed [COORD_BITS-1:0] from_z,
    input  logic [7:0]                   start_group,
    input  logic [7:0]                   avoid_group,
    output logic                         done,
    output logic [2:0]                   status,
    output logic [INDEX_BITS-1:0]        portal_index,
    output logic [COUNT_BITS-1:0]        portal_count,
    output logic                         is_ahead,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic signed [COORD_BITS-1:0] out_z
);

    ptes_cmd_t  ctl;
    ptes_stat_t stat;

    ptes_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctl   (ctl),
        .stat  (stat)
    );

    ptes_datapath #(.PORTALS(PORTALS), .COORD_BITS(COORD_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .cmd          (cmd),
        .group_a      (group_a),
        .group_b      (group_b),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .from_x       (from_x),
        .from_y       (from_y),
        .from_z       (from_z),
        .start_group  (start_group),
        .avoid_group  (avoid_group),
        .done         (done),
        .status       (status),
        .portal_index (portal_index),
        .portal_count (portal_count),
        .is_ahead     (is_ahead),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_z        (out_z)
    );

endmodule
